// ===== rtl/u8d_pkg.sv =====
package u8d_pkg;

	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;
	localparam int CP_W      = 31;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ILLEGAL    = 2'd1,
		ST_INCOMPLETE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_ASCII = 2'd0,
		K_CONT  = 2'd1,
		K_LEAD  = 2'd2,
		K_BAD   = 2'd3
	} kind_t;

	// one classified input word
	typedef struct packed {
		kind_t      kind;
		logic [2:0] len;
		logic [6:0] bits;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic [2:0]      seq_length;
		status_t         status;
	} res_t;

	// smallest value that is not overlong for a sequence of len bytes
	function automatic logic [CP_W-1:0] min_value(input logic [2:0] len);
		logic [CP_W-1:0] v;
		v = '0;
		case (len)
			3'd2:    v = CP_W'(32'h80);
			3'd3:    v = CP_W'(32'h800);
			3'd4:    v = CP_W'(32'h10000);
			3'd5:    v = CP_W'(32'h200000);
			3'd6:    v = CP_W'(32'h4000000);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/u8d_fifo.sv =====
module u8d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/u8d_front.sv =====
module u8d_front #(
	parameter int DEPTH = u8d_pkg::CMD_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    data_byte,
	input  logic          end_of_input,
	output logic          full,
	input  logic          cmd_pop,
	output u8d_pkg::cmd_t cmd,
	output logic          cmd_empty
);

	u8d_pkg::cmd_t cls;

	always_comb begin
		cls.last = end_of_input;
		cls.kind = u8d_pkg::K_BAD;
		cls.len  = 3'd0;
		cls.bits = '0;
		unique casez (data_byte)
			8'b0???????: begin
				cls.kind = u8d_pkg::K_ASCII;
				cls.len  = 3'd1;
				cls.bits = data_byte[6:0];
			end
			8'b10??????: begin
				cls.kind = u8d_pkg::K_CONT;
				cls.bits = {1'b0, data_byte[5:0]};
			end
			8'b110?????: begin
				cls.kind = u8d_pkg::K_LEAD;
				cls.len  = 3'd2;
				cls.bits = {2'b0, data_byte[4:0]};
			end
			8'b1110????: begin
				cls.kind = u8d_pkg::K_LEAD;
				cls.len  = 3'd3;
				cls.bits = {3'b0, data_byte[3:0]};
			end
			8'b11110???: begin
				cls.kind = u8d_pkg::K_LEAD;
				cls.len  = 3'd4;
				cls.bits = {4'b0, data_byte[2:0]};
			end
			8'b111110??: begin
				cls.kind = u8d_pkg::K_LEAD;
				cls.len  = 3'd5;
				cls.bits = {5'b0, data_byte[1:0]};
			end
			8'b1111110?: begin
				cls.kind = u8d_pkg::K_LEAD;
				cls.len  = 3'd6;
				cls.bits = {6'b0, data_byte[0]};
			end
			default: begin
				cls.kind = u8d_pkg::K_BAD;
			end
		endcase
	end

	u8d_fifo #(
		.WIDTH ($bits(u8d_pkg::cmd_t)),
		.DEPTH (DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd),
		.empty  (cmd_empty)
	);

endmodule

// ===== rtl/u8d_back.sv =====
module u8d_back (
	input  logic          clk,
	input  logic          arst_n,
	input  u8d_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	output logic          res_push,
	output u8d_pkg::res_t res,
	input  logic          res_full
);

	logic [u8d_pkg::CP_W-1:0] partial_q, next_pv;
	logic [2:0]               pending_q, size_q, pend_dec;
	logic                     emit, go_idle, start;

	assign cmd_pop  = ~cmd_empty & ~res_full;
	assign res_push = cmd_pop & emit;
	assign next_pv  = {partial_q[u8d_pkg::CP_W-7:0], cmd.bits[5:0]};
	assign pend_dec = pending_q - 3'd1;

	always_comb begin
		emit           = 1'b0;
		go_idle        = 1'b0;
		start          = 1'b0;
		res.code_point = '0;
		res.seq_length = '0;
		res.status     = u8d_pkg::ST_OK;
		if (pending_q == '0) begin
			case (cmd.kind)
				u8d_pkg::K_ASCII: begin
					emit           = 1'b1;
					res.code_point = u8d_pkg::CP_W'(cmd.bits);
					res.seq_length = 3'd1;
				end
				u8d_pkg::K_LEAD: begin
					if (cmd.last) begin
						emit       = 1'b1;
						res.status = u8d_pkg::ST_INCOMPLETE;
					end else begin
						start = 1'b1;
					end
				end
				default: begin
					emit       = 1'b1;
					res.status = u8d_pkg::ST_ILLEGAL;
				end
			endcase
		end else if (cmd.kind != u8d_pkg::K_CONT) begin
			emit       = 1'b1;
			go_idle    = 1'b1;
			res.status = u8d_pkg::ST_ILLEGAL;
		end else if (pend_dec == '0) begin
			emit    = 1'b1;
			go_idle = 1'b1;
			if (next_pv >= u8d_pkg::min_value(size_q)) begin
				res.code_point = next_pv;
				res.seq_length = size_q;
			end else begin
				res.status = u8d_pkg::ST_ILLEGAL;
			end
		end else if (cmd.last) begin
			emit       = 1'b1;
			go_idle    = 1'b1;
			res.status = u8d_pkg::ST_INCOMPLETE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pending_q <= '0;
			size_q    <= '0;
		end else if (cmd_pop) begin
			if (start) begin
				partial_q <= u8d_pkg::CP_W'(cmd.bits);
				pending_q <= cmd.len - 3'd1;
				size_q    <= cmd.len;
			end else if (go_idle) begin
				partial_q <= '0;
				pending_q <= '0;
				size_q    <= '0;
			end else if (pending_q != '0) begin
				partial_q <= next_pv;
				pending_q <= pend_dec;
			end
		end
	end

	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd5)
		else $error("pending count out of range");

	a_size_covers_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != '0) |-> (size_q > pending_q && size_q <= 3'd6))
		else $error("sequence size inconsistent with pending count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.status != u8d_pkg::ST_OK) |->
		(res.code_point == '0 && res.seq_length == '0))
		else $error("error word carries payload");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.status == u8d_pkg::ST_OK) |-> (res.seq_length != '0))
		else $error("ok word with zero length");

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// Byte-serial decoder for original UTF-8 (sequences of 1 to 6 bytes). Input and results are
// both queues: write a byte with push while full is low, read results while empty is low.
// One byte is taken every clock while full is low; the byte is classified into the command
// queue, then the back end writes its result into the result queue. Steady throughput is
// one byte per cycle when the result queue is not full, set by the shift-and-or in the
// back end. A byte that only extends a sequence produces no result word. Errors (stray
// continuation, 0xFE/0xFF, bad continuation, overlong value) give status illegal and
// decoding resumes at the next byte; end_of_input inside a sequence gives status incomplete.
module utf8_stream_decoder #(
	parameter int CMD_DEPTH = u8d_pkg::CMD_DEPTH,
	parameter int RES_DEPTH = u8d_pkg::RES_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_input,
	input  logic        pop,
	output logic        empty,
	output logic [30:0] code_point,
	output logic [2:0]  seq_length,
	output logic [1:0]  status
);

	u8d_pkg::cmd_t cmd;
	u8d_pkg::res_t res, res_head;
	logic          cmd_empty, cmd_pop, res_push, res_full;

	u8d_front #(
		.DEPTH (CMD_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.full         (full),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd),
		.cmd_empty    (cmd_empty)
	);

	u8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	u8d_fifo #(
		.WIDTH ($bits(u8d_pkg::res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign code_point = res_head.code_point;
	assign seq_length = res_head.seq_length;
	assign status     = res_head.status;

endmodule
